// ===== sv/pcfd_pkg.sv =====
`default_nettype none

package pcfd_pkg;

   localparam int unsigned MAX_YEAR_DEF = 9999;

   localparam int unsigned DAY_W  = 5;
   localparam int unsigned MON_W  = 4;
   localparam int unsigned YEAR_W = 14;
   // day number of 31 Dec 16383 stays below 2^23
   localparam int unsigned DN_W   = 23;
   localparam int unsigned RES_W  = 8;

   typedef logic [DN_W-1:0]  day_num_type;
   typedef logic [RES_W-1:0] res_type;
   typedef logic [3:0]       mon_idx_type;

   localparam res_type CYCLE_LEN = 8'd210;
   // 5 Jan 2020 has day number 737429, which is 119 mod 210
   localparam res_type REF_RES   = 8'd119;
   localparam res_type REF_WRAP  = 8'd91;

   // reciprocal constants, exact over the ranges used
   localparam logic [10:0] RECIP_Q25  = 11'd1311;        // (p>>2)/25, shift 15
   localparam logic [12:0] RECIP_Y25  = 13'd5243;        // y/25, shift 17
   localparam logic [23:0] RECIP_C210 = 24'd10226113;    // n/210, shift 31
   localparam logic [8:0]  RECIP_7    = 9'd293;          // r/7, shift 11
   localparam logic [7:0]  RECIP_5    = 8'd205;          // r/5, shift 10
   localparam logic [7:0]  RECIP_3    = 8'd171;          // r/3, shift 9

   localparam logic [8:0] CUM_DAYS [12] =
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

   localparam logic [4:0] MON_LEN [12] =
      '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

endpackage

`default_nettype wire

// ===== sv/pcfd_day_num.sv =====
`default_nettype none

module pcfd_day_num #(
   parameter int unsigned MAX_YEAR = pcfd_pkg::MAX_YEAR_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [pcfd_pkg::YEAR_W-1:0]   year,
   input  wire logic [pcfd_pkg::MON_W-1:0]    month,
   input  wire logic [pcfd_pkg::DAY_W-1:0]    day,
   output pcfd_pkg::day_num_type              day_num,
   output logic                               date_ok
);

   // stage 1: clamp month, table reads, (year-1)/100 and year/25 by reciprocal
   logic [pcfd_pkg::MON_W-1:0]  mon_c;
   pcfd_pkg::mon_idx_type       idx;
   logic [pcfd_pkg::YEAR_W-1:0] p_in;
   logic [22:0]                 q100_prod;
   logic [26:0]                 y25_prod;
   logic                        fields_ok_in;

   logic [pcfd_pkg::YEAR_W-1:0] p_ff;
   logic [pcfd_pkg::YEAR_W-1:0] year_ff;
   logic [7:0]                  q100_ff;
   logic [9:0]                  y25_ff;
   logic [8:0]                  cum_ff;
   logic [4:0]                  mlen_ff;
   logic                        feb_ff;
   logic                        after_feb_ff;
   logic [pcfd_pkg::DAY_W-1:0]  day_ff;
   logic                        fields_ok_ff;

   always_comb begin
      if (month == '0) begin
         mon_c = 4'd1;
      end else if (month > 4'd12) begin
         mon_c = 4'd12;
      end else begin
         mon_c = month;
      end
      idx          = mon_c - 4'd1;
      p_in         = (year == '0) ? '0 : year - 14'd1;
      q100_prod    = 23'(p_in[13:2]) * 23'(pcfd_pkg::RECIP_Q25);
      y25_prod     = 27'(year) * 27'(pcfd_pkg::RECIP_Y25);
      fields_ok_in = (year != '0) && (17'(year) <= 17'(MAX_YEAR)) &&
                     (month != '0) && (month <= 4'd12) && (day != '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff         <= p_in;
         year_ff      <= year;
         q100_ff      <= q100_prod[22:15];
         y25_ff       <= y25_prod[26:17];
         cum_ff       <= pcfd_pkg::CUM_DAYS[idx];
         mlen_ff      <= pcfd_pkg::MON_LEN[idx];
         feb_ff       <= (mon_c == 4'd2);
         after_feb_ff <= (mon_c > 4'd2);
         day_ff       <= day;
         fields_ok_ff <= fields_ok_in;
      end
   end

   // stage 2: leap year, days before the year, days within the year
   logic                  z25;
   logic                  leap;
   pcfd_pkg::day_num_type base_in;
   logic [9:0]            part_in;
   logic                  ok_in;

   pcfd_pkg::day_num_type base_ff;
   logic [9:0]            part_ff;
   logic                  ok2_ff;

   always_comb begin
      z25     = ((15'(y25_ff) * 15'd25) == 15'(year_ff));
      // divisible by 100 means by 4 and by 25; by 400 means by 16 and by 25
      leap    = ((year_ff[1:0] == 2'd0) && !z25) || ((year_ff[3:0] == 4'd0) && z25);
      base_in = 23'(p_ff) * 23'd365 + 23'(p_ff[13:2]) - 23'(q100_ff) + 23'(q100_ff[7:2]);
      part_in = 10'(cum_ff) + 10'(leap && after_feb_ff) + 10'(day_ff);
      ok_in   = fields_ok_ff && (6'(day_ff) <= (6'(mlen_ff) + 6'(leap && feb_ff)));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         base_ff <= base_in;
         part_ff <= part_in;
         ok2_ff  <= ok_in;
      end
   end

   // stage 3: final sum
   pcfd_pkg::day_num_type dn_ff;
   logic                  ok3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dn_ff  <= base_ff + 23'(part_ff);
         ok3_ff <= ok2_ff;
      end
   end

   assign day_num = dn_ff;
   assign date_ok = ok3_ff;

endmodule

`default_nettype wire

// ===== sv/pcfd_mod210.sv =====
`default_nettype none

module pcfd_mod210 (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire pcfd_pkg::day_num_type day_num,
   output pcfd_pkg::res_type          residue
);

   logic [46:0]           prod;
   logic [15:0]           q_ff;
   pcfd_pkg::day_num_type n_ff;
   pcfd_pkg::res_type     res_ff;
   pcfd_pkg::day_num_type rem_full;

   assign prod = 47'(day_num) * 47'(pcfd_pkg::RECIP_C210);

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= prod[46:31];
         n_ff <= day_num;
      end
   end

   // quotient is exact, so no correction step
   assign rem_full = n_ff - 23'(q_ff) * 23'(pcfd_pkg::CYCLE_LEN);

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= rem_full[7:0];
      end
   end

   assign residue = res_ff;

endmodule

`default_nettype wire

// ===== sv/pcfd_pawukon.sv =====
`default_nettype none

module pcfd_pawukon (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire pcfd_pkg::res_type res_birth,
   input  wire pcfd_pkg::res_type res_today,
   input  wire logic              birth_ge,
   input  wire logic              date_ok,
   output logic                   date_valid,
   output logic [4:0]             wuku_index,
   output logic [2:0]             seven_day_index,
   output logic [2:0]             five_day_index,
   output logic [1:0]             three_day_index,
   output logic [7:0]             days_until_next
);

   // stage 6: position in the 210-day cycle and distance mod 210
   pcfd_pkg::res_type r_in;
   pcfd_pkg::res_type dist_in;
   logic [8:0]        diff_bt;
   logic [8:0]        diff_tb;

   pcfd_pkg::res_type r_ff;
   pcfd_pkg::res_type dist_ff;
   logic              ok_ff;

   always_comb begin
      if (res_birth >= pcfd_pkg::REF_RES) begin
         r_in = res_birth - pcfd_pkg::REF_RES;
      end else begin
         r_in = res_birth + pcfd_pkg::REF_WRAP;
      end
      diff_bt = (res_birth >= res_today) ? 9'(res_birth) - 9'(res_today)
                : 9'(res_birth) + 9'(pcfd_pkg::CYCLE_LEN) - 9'(res_today);
      diff_tb = (res_today >= res_birth) ? 9'(res_today) - 9'(res_birth)
                : 9'(res_today) + 9'(pcfd_pkg::CYCLE_LEN) - 9'(res_birth);
      dist_in = birth_ge ? diff_bt[7:0] : diff_tb[7:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff    <= r_in;
         dist_ff <= dist_in;
         ok_ff   <= date_ok;
      end
   end

   // stage 7: split the position into the week and the three day cycles
   logic [16:0]       p7;
   logic [15:0]       p5;
   logic [15:0]       p3;
   pcfd_pkg::res_type s7;
   pcfd_pkg::res_type s5;
   pcfd_pkg::res_type s3;

   logic              valid_ff;
   logic [4:0]        wuku_ff;
   logic [2:0]        sapta_ff;
   logic [2:0]        panca_ff;
   logic [1:0]        tri_ff;
   logic [7:0]        days_ff;

   always_comb begin
      p7 = 17'(r_ff) * 17'(pcfd_pkg::RECIP_7);
      p5 = 16'(r_ff) * 16'(pcfd_pkg::RECIP_5);
      p3 = 16'(r_ff) * 16'(pcfd_pkg::RECIP_3);
      s7 = r_ff - 8'(p7[16:11]) * 8'd7;
      s5 = r_ff - 8'(p5[15:10]) * 8'd5;
      s3 = r_ff - 8'(p3[15:9]) * 8'd3;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         valid_ff <= ok_ff;
         if (ok_ff) begin
            wuku_ff  <= p7[15:11];
            sapta_ff <= s7[2:0];
            panca_ff <= s5[2:0];
            tri_ff   <= s3[1:0];
            days_ff  <= pcfd_pkg::CYCLE_LEN - dist_ff;
         end else begin
            wuku_ff  <= '0;
            sapta_ff <= '0;
            panca_ff <= '0;
            tri_ff   <= '0;
            days_ff  <= '0;
         end
      end
   end

   assign date_valid      = valid_ff;
   assign wuku_index      = wuku_ff;
   assign seven_day_index = sapta_ff;
   assign five_day_index  = panca_ff;
   assign three_day_index = tri_ff;
   assign days_until_next = days_ff;

endmodule

`default_nettype wire

// ===== sv/pawukon_cycle_from_date.sv =====
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  birth and today dates
// rsp      out        rsp_valid/rsp_ready  date_valid, pawukon indices, days to otonan
//
// Seven register stages; one item a cycle while rsp is not stalled.
// Stages 1-3 build the day numbers, 4-5 reduce them mod 210, 6-7 form the indices.
// Synchronous reset clears only the stage valid bits.
// A stalled rsp freezes the whole pipeline; req_ready follows rsp_ready then.
`default_nettype none

module pawukon_cycle_from_date #(
   parameter int unsigned MAX_YEAR = pcfd_pkg::MAX_YEAR_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [pcfd_pkg::DAY_W-1:0]  req_birth_day,
   input  wire logic [pcfd_pkg::MON_W-1:0]  req_birth_month,
   input  wire logic [pcfd_pkg::YEAR_W-1:0] req_birth_year,
   input  wire logic [pcfd_pkg::DAY_W-1:0]  req_today_day,
   input  wire logic [pcfd_pkg::MON_W-1:0]  req_today_month,
   input  wire logic [pcfd_pkg::YEAR_W-1:0] req_today_year,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_date_valid,
   output logic [4:0]                       rsp_wuku_index,
   output logic [2:0]                       rsp_seven_day_index,
   output logic [2:0]                       rsp_five_day_index,
   output logic [1:0]                       rsp_three_day_index,
   output logic [7:0]                       rsp_days_until_next
);

   localparam int unsigned STAGES = 7;

   logic                  en;
   logic [STAGES-1:0]     vld_ff;
   logic [STAGES-1:0]     vld_in;

   pcfd_pkg::day_num_type dn_birth;
   pcfd_pkg::day_num_type dn_today;
   logic                  birth_ok;
   logic                  today_ok;
   pcfd_pkg::res_type     res_birth;
   pcfd_pkg::res_type     res_today;

   logic                  ge4_ff;
   logic                  ge5_ff;
   logic                  ok4_ff;
   logic                  ok5_ff;

   assign en        = !vld_ff[STAGES-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[STAGES-1];
   assign vld_in    = {vld_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   pcfd_day_num #(.MAX_YEAR(MAX_YEAR)) u_dn_birth (
      .clock   (clock),
      .en      (en),
      .year    (req_birth_year),
      .month   (req_birth_month),
      .day     (req_birth_day),
      .day_num (dn_birth),
      .date_ok (birth_ok)
   );

   // today is never checked; its validity flag is left aside
   pcfd_day_num #(.MAX_YEAR(MAX_YEAR)) u_dn_today (
      .clock   (clock),
      .en      (en),
      .year    (req_today_year),
      .month   (req_today_month),
      .day     (req_today_day),
      .day_num (dn_today),
      .date_ok (today_ok)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         ge4_ff <= (dn_birth >= dn_today);
         ge5_ff <= ge4_ff;
         ok4_ff <= birth_ok;
         ok5_ff <= ok4_ff;
      end
   end

   pcfd_mod210 u_mod_birth (
      .clock   (clock),
      .en      (en),
      .day_num (dn_birth),
      .residue (res_birth)
   );

   pcfd_mod210 u_mod_today (
      .clock   (clock),
      .en      (en),
      .day_num (dn_today),
      .residue (res_today)
   );

   pcfd_pawukon u_pawukon (
      .clock           (clock),
      .en              (en),
      .res_birth       (res_birth),
      .res_today       (res_today),
      .birth_ge        (ge5_ff),
      .date_ok         (ok5_ff),
      .date_valid      (rsp_date_valid),
      .wuku_index      (rsp_wuku_index),
      .seven_day_index (rsp_seven_day_index),
      .five_day_index  (rsp_five_day_index),
      .three_day_index (rsp_three_day_index),
      .days_until_next (rsp_days_until_next)
   );

   // an invalid birth date carries nothing but zeros
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_date_valid) |->
         (rsp_wuku_index == '0 && rsp_seven_day_index == '0 &&
          rsp_five_day_index == '0 && rsp_three_day_index == '0 &&
          rsp_days_until_next == '0))
      else $error("invalid date item with non-zero fields");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_date_valid) |->
         (rsp_wuku_index < 5'd30 && rsp_seven_day_index < 3'd7 &&
          rsp_five_day_index < 3'd5 && rsp_three_day_index < 2'd3))
      else $error("pawukon index out of range");

   a_days_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_date_valid) |->
         (rsp_days_until_next != '0 && rsp_days_until_next <= 8'd210))
      else $error("days to otonan out of range");

   a_ready_on_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");

endmodule

`default_nettype wire

// ===== verif/pawukon_cycle_from_date_tb.sv =====
module pawukon_cycle_from_date_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int unsigned BIRTH_YEAR_MAX  = pcfd_pkg::MAX_YEAR_DEF;
   localparam int unsigned RANDOM_SEGMENTS = 13;
   localparam int unsigned SEGMENT_ITEMS   = 150;
   localparam int unsigned LONG_HOLD       = 300;
   localparam int unsigned SETTLE_CYCLES   = 20;

   typedef logic [pcfd_pkg::DAY_W-1:0]  day_type;
   typedef logic [pcfd_pkg::MON_W-1:0]  mon_type;
   typedef logic [pcfd_pkg::YEAR_W-1:0] year_type;

   typedef struct packed {
      day_type  bday;
      mon_type  bmon;
      year_type byear;
      day_type  tday;
      mon_type  tmon;
      year_type tyear;
   } date_pair_type;

   typedef struct packed {
      logic       valid;
      logic [4:0] wuku;
      logic [2:0] saptawara;
      logic [2:0] pancawara;
      logic [1:0] triwara;
      logic [7:0] days;
   } otonan_type;

   // typed = 1: expected fields written in the row, else taken from the predictor
   typedef struct {
      int bd, bm, by, td, tm, ty;
      bit typed;
      int v, wk, s7, s5, s3, days;
   } date_row_type;

   localparam int DIRECTED_ROWS = 24;

   date_row_type date_rows [DIRECTED_ROWS] = '{
      '{ 5,  1,  2020,  5,  1,  2020, 1, 1,  0, 0, 0, 0, 210},
      '{ 4,  1,  2020,  4,  1,  2020, 1, 1, 29, 6, 4, 2, 210},
      '{ 6,  1,  2020,  5,  1,  2020, 1, 1,  0, 1, 1, 1, 209},
      '{12,  1,  2020, 12,  1,  2020, 1, 1,  1, 0, 2, 1, 210},
      '{ 0,  1,  2020,  5,  1,  2020, 1, 0,  0, 0, 0, 0,   0},
      '{31,  4,  2000,  1,  1,  2000, 1, 0,  0, 0, 0, 0,   0},
      '{ 1,  0,  2000,  1,  1,  2000, 1, 0,  0, 0, 0, 0,   0},
      '{ 1, 13,  2000,  1,  1,  2000, 1, 0,  0, 0, 0, 0,   0},
      '{31, 15, 16383,  1,  1,  2000, 1, 0,  0, 0, 0, 0,   0},
      '{ 1,  1,     0,  1,  1,  2000, 1, 0,  0, 0, 0, 0,   0},
      '{ 1,  1, 10000,  1,  1,  2000, 1, 0,  0, 0, 0, 0,   0},
      '{29,  2,  2001,  1,  1,  2001, 1, 0,  0, 0, 0, 0,   0},
      '{29,  2,  1900,  1,  1,  1900, 1, 0,  0, 0, 0, 0,   0},
      '{29,  2,  2000,  1,  3,  2000, 0, 0,  0, 0, 0, 0,   0},
      '{29,  2,  2024, 28,  2,  2025, 0, 0,  0, 0, 0, 0,   0},
      '{ 1,  1,     1, 31, 12,  9999, 0, 0,  0, 0, 0, 0,   0},
      '{31, 12,  9999,  1,  1,     1, 0, 0,  0, 0, 0, 0,   0},
      '{ 1,  1,  2100,  1,  1,  2000, 0, 0,  0, 0, 0, 0,   0},
      '{15,  8,  1990,  1,  0,  2024, 0, 0,  0, 0, 0, 0,   0},
      '{15,  8,  1990,  1, 15,  2024, 0, 0,  0, 0, 0, 0,   0},
      '{15,  8,  1990,  0,  3,  2024, 0, 0,  0, 0, 0, 0,   0},
      '{15,  8,  1990, 31,  2,  2023, 0, 0,  0, 0, 0, 0,   0},
      '{15,  8,  1990, 31, 15,     0, 0, 0,  0, 0, 0, 0,   0},
      '{15,  8,  1990, 31, 15, 16383, 0, 0,  0, 0, 0, 0,   0}
   };

   logic     clock = 1'b0;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   day_type  req_birth_day;
   mon_type  req_birth_month;
   year_type req_birth_year;
   day_type  req_today_day;
   mon_type  req_today_month;
   year_type req_today_year;
   logic     rsp_valid;
   logic     rsp_ready;
   logic        rsp_date_valid;
   logic [4:0]  rsp_wuku_index;
   logic [2:0]  rsp_seven_day_index;
   logic [2:0]  rsp_five_day_index;
   logic [1:0]  rsp_three_day_index;
   logic [7:0]  rsp_days_until_next;

   otonan_type  otonan_queue [$];
   otonan_type  offered_otonan;
   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;
   bit          tx_calm     = 1'b0;
   bit          rx_calm     = 1'b0;
   bit          rx_hold_req = 1'b0;

   pawukon_cycle_from_date dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_birth_day       (req_birth_day),
      .req_birth_month     (req_birth_month),
      .req_birth_year      (req_birth_year),
      .req_today_day       (req_today_day),
      .req_today_month     (req_today_month),
      .req_today_year      (req_today_year),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_date_valid      (rsp_date_valid),
      .rsp_wuku_index      (rsp_wuku_index),
      .rsp_seven_day_index (rsp_seven_day_index),
      .rsp_five_day_index  (rsp_five_day_index),
      .rsp_three_day_index (rsp_three_day_index),
      .rsp_days_until_next (rsp_days_until_next)
   );

   always #6 clock = ~clock;

   function automatic bit leap_year(longint y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   function automatic int days_in_month(int m, longint y);
      return int'(pcfd_pkg::MON_LEN[m-1]) + ((m == 2 && leap_year(y)) ? 1 : 0);
   endfunction

   // today's month is clamped, its day is taken as is
   function automatic longint day_count(longint y, longint m, longint d);
      longint n;
      longint p;
      n = 0;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      if (y >= 1) begin
         p = y - 1;
         n = 365 * p + p / 4 - p / 100 + p / 400;
      end
      for (int i = 1; i < m; i++) n += days_in_month(i, y);
      return n + d;
   endfunction

   function automatic otonan_type otonan_of(date_pair_type x);
      otonan_type r;
      longint     nb, nr, nt, d, span;
      r = '0;
      if (x.byear < 1 || x.byear > BIRTH_YEAR_MAX || x.bmon < 1 || x.bmon > 12 ||
          x.bday < 1 || x.bday > days_in_month(int'(x.bmon), longint'(x.byear)))
         return r;
      nb = day_count(x.byear, x.bmon, x.bday);
      nr = day_count(2020, 1, 5);
      nt = day_count(x.tyear, x.tmon, x.tday);
      if (nb >= nr) begin
         d = nb - nr;
         r.wuku      = 5'((d / 7) % 30);
         r.saptawara = 3'(d % 7);
         r.pancawara = 3'(d % 5);
         r.triwara   = 2'(d % 3);
      end else begin
         // counting backward from the reference
         d = nr - nb;
         r.wuku      = 5'(29 - ((d - 1) / 7) % 30);
         r.saptawara = 3'((7 - d % 7) % 7);
         r.pancawara = 3'((5 - d % 5) % 5);
         r.triwara   = 2'((3 - d % 3) % 3);
      end
      span   = (nb >= nt) ? nb - nt : nt - nb;
      r.days = 8'(210 - span % 210);
      r.valid = 1'b1;
      return r;
   endfunction

   function automatic date_pair_type random_dates();
      date_pair_type x;
      int r;
      int y, m;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         x.bday  = day_type'($urandom_range(0, 31));
         x.bmon  = mon_type'($urandom_range(0, 15));
         x.byear = year_type'($urandom_range(0, 16383));
      end else begin
         if (r < 40)      y = $urandom_range(2015, 2025);
         else if (r < 80) y = $urandom_range(1800, 2200);
         else             y = $urandom_range(1, BIRTH_YEAR_MAX);
         m = $urandom_range(1, 12);
         x.byear = year_type'(y);
         x.bmon  = mon_type'(m);
         x.bday  = day_type'($urandom_range(1, days_in_month(m, y)));
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
         x.tday  = day_type'($urandom_range(0, 31));
         x.tmon  = mon_type'($urandom_range(0, 15));
         x.tyear = year_type'($urandom_range(0, 16383));
      end else begin
         y = (r < 75) ? $urandom_range(1900, 2100) : $urandom_range(1, BIRTH_YEAR_MAX);
         m = $urandom_range(1, 12);
         x.tyear = year_type'(y);
         x.tmon  = mon_type'(m);
         x.tday  = day_type'($urandom_range(1, days_in_month(m, y)));
      end
      return x;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_len(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // entered and left at a falling edge
   task automatic offer_dates(date_pair_type x, otonan_type want);
      int gap;
      gap = idle_len(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_birth_day   <= x.bday;
      req_birth_month <= x.bmon;
      req_birth_year  <= x.byear;
      req_today_day   <= x.tday;
      req_today_month <= x.tmon;
      req_today_year  <= x.tyear;
      req_valid       <= 1'b1;
      offered_otonan  = want;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic await_drain();
      while (otonan_queue.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      otonan_type want;
      if (!reset) begin
         if (req_valid && req_ready) otonan_queue.push_back(offered_otonan);
         if (rsp_valid && rsp_ready) begin
            if (otonan_queue.size() == 0) begin
               $error("result with no item outstanding");
               fail_count++;
            end else begin
               want = otonan_queue.pop_front();
               check_field("date_valid", want.valid, rsp_date_valid);
               check_field("wuku_index", want.wuku, rsp_wuku_index);
               check_field("seven_day_index", want.saptawara, rsp_seven_day_index);
               check_field("five_day_index", want.pancawara, rsp_five_day_index);
               check_field("three_day_index", want.triwara, rsp_three_day_index);
               check_field("days_until_next", want.days, rsp_days_until_next);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pawukon_cycle_from_date_tb failed");
         $finish;
      end
   end

   // result side: open for a while, then a stall (or the long hold when asked)
   initial begin : result_sink
      int  n;
      bit  holding;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         holding = rx_hold_req;
         n = holding ? LONG_HOLD : idle_len(rx_calm);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         if (holding) rx_hold_req = 1'b0;
      end
   end

   initial begin : date_source
      date_pair_type x;
      otonan_type    want;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_birth_day   = '0;
      req_birth_month = '0;
      req_birth_year  = '0;
      req_today_day   = '0;
      req_today_month = '0;
      req_today_year  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (date_rows[i]) begin
         x.bday  = day_type'(date_rows[i].bd);
         x.bmon  = mon_type'(date_rows[i].bm);
         x.byear = year_type'(date_rows[i].by);
         x.tday  = day_type'(date_rows[i].td);
         x.tmon  = mon_type'(date_rows[i].tm);
         x.tyear = year_type'(date_rows[i].ty);
         if (date_rows[i].typed)
            want = '{1'(date_rows[i].v), 5'(date_rows[i].wk), 3'(date_rows[i].s7),
                     3'(date_rows[i].s5), 2'(date_rows[i].s3), 8'(date_rows[i].days)};
         else
            want = otonan_of(x);
         offer_dates(x, want);
      end

      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         // sink held off while items keep coming: pipeline fills, req_ready drops
         if (seg == 2) begin
            tx_calm     = 1'b1;
            rx_hold_req = 1'b1;
         end
         // source pauses until every result is back
         if (seg == 6) begin
            req_valid <= 1'b0;
            await_drain();
            @(negedge clock);
         end
         for (int k = 0; k < SEGMENT_ITEMS; k++) begin
            x = random_dates();
            offer_dates(x, otonan_of(x));
         end
      end

      req_valid <= 1'b0;
      await_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("pawukon_cycle_from_date_tb passed");
      else
         $display("pawukon_cycle_from_date_tb failed");
      $finish;
   end

endmodule
